// ===== design/adp_pkg.sv =====
// Shared types, constants and state codes for the Adam parameter update block.
`default_nettype none
package adp_pkg;

	localparam int NUM_PARAMS  = 1024;
	localparam int ADDR_W      = $clog2(NUM_PARAMS);
	localparam int IDX_W       = 10;
	localparam int DATA_W      = 32;
	localparam int MOM_W       = 48;
	localparam int PWR_W       = 33;
	localparam int GRAD_W      = 28;
	localparam int QUEUE_DEPTH = 2;
	localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

	// gradient clip, +-5.0 in Q8.24
	localparam logic signed [33:0] CLIP_LIMIT = 34'sd83886080;
	localparam logic [PWR_W-1:0]   ONE_Q32    = 33'h1_0000_0000;

	// saturation limits and pre-shifts of the three divisions
	localparam logic [62:0] LIM_MHAT  = 63'h0000_7FFF_FFFF_FFFF;
	localparam logic [62:0] LIM_VHAT  = 63'h0000_FFFF_FFFF_FFFF;
	localparam logic [62:0] LIM_RATIO = 63'h4000_0000_0000_0000;
	localparam logic [5:0]  SH_HAT    = 6'd32;
	localparam logic [5:0]  SH_RATIO  = 6'd24;

	// configuration register indexes
	localparam logic [2:0] CFG_LR  = 3'd0;
	localparam logic [2:0] CFG_L2  = 3'd1;
	localparam logic [2:0] CFG_B1  = 3'd2;
	localparam logic [2:0] CFG_B2  = 3'd3;
	localparam logic [2:0] CFG_EPS = 3'd4;

	localparam logic [31:0] RST_LR  = 32'd4294967;
	localparam logic [31:0] RST_L2  = 32'd0;
	localparam logic [31:0] RST_B1  = 32'd3865470566;
	localparam logic [31:0] RST_B2  = 32'd4290672329;
	localparam logic [47:0] RST_EPS = 48'd10995;

	// product slots of the shared Q32 multiplier
	localparam logic [2:0] MUL_BP1  = 3'd0;
	localparam logic [2:0] MUL_BP2  = 3'd1;
	localparam logic [2:0] MUL_MB   = 3'd2;
	localparam logic [2:0] MUL_MG   = 3'd3;
	localparam logic [2:0] MUL_VB   = 3'd4;
	localparam logic [2:0] MUL_VG   = 3'd5;
	localparam logic [2:0] MUL_STEP = 3'd6;

	typedef struct packed {
		logic [IDX_W-1:0]         param_index;
		logic signed [DATA_W-1:0] grad_value;
		logic signed [DATA_W-1:0] param_value;
		logic                     grad_invalid;
		logic                     new_step;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0]         out_index;
		logic signed [DATA_W-1:0] new_param;
	} rsp_t;

	typedef struct packed {
		logic [IDX_W-1:0]         idx;
		logic signed [GRAD_W-1:0] grad;
		logic signed [DATA_W-1:0] param;
		logic                     adv;
	} work_t;

	typedef struct packed {
		logic [31:0]      step_size;
		logic [31:0]      l2_decay;
		logic [31:0]      beta_one;
		logic [31:0]      beta_two;
		logic [MOM_W-1:0] epsilon_term;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD,
		ST_MLO,
		ST_MHI,
		ST_MOM,
		ST_DIVA,
		ST_SQ,
		ST_DEN,
		ST_DIVB,
		ST_FIN,
		ST_OUT
	} back_st_t;

endpackage
`default_nettype wire

// ===== design/adp_front.sv =====
// Front end: accepts requests, conditions the gradient, decides step advance.
`default_nettype none
module adp_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire adp_pkg::req_t  request,
	input  wire logic [31:0]    l2_decay,
	input  wire logic           q_full,
	input  wire logic           clearing,
	output logic                full,
	output logic                wr_en,
	output adp_pkg::work_t      wr_data
);

	logic              step_started_q;
	logic              p_neg;
	logic [31:0]       p_mag;
	logic [63:0]       prod;
	logic [31:0]       decay_mag;
	logic signed [33:0] decay;
	logic signed [33:0] g_sum;
	logic signed [33:0] g_clip;

	assign full  = q_full | clearing;
	assign wr_en = push & ~full;

	always_comb begin
		p_neg     = request.param_value[31];
		p_mag     = p_neg ? 32'(-request.param_value) : 32'(request.param_value);
		prod      = 64'(p_mag) * 64'(l2_decay) + 64'h8000_0000;
		decay_mag = prod[63:32];
		decay     = p_neg ? -$signed({2'b00, decay_mag}) : $signed({2'b00, decay_mag});
		g_sum     = 34'(request.grad_value) + decay;
		if (g_sum > adp_pkg::CLIP_LIMIT)
			g_clip = adp_pkg::CLIP_LIMIT;
		else if (g_sum < -adp_pkg::CLIP_LIMIT)
			g_clip = -adp_pkg::CLIP_LIMIT;
		else
			g_clip = g_sum;
		wr_data.idx   = request.param_index;
		wr_data.grad  = request.grad_invalid ? '0 : adp_pkg::GRAD_W'(g_clip);
		wr_data.param = request.param_value;
		wr_data.adv   = request.new_step | ~step_started_q;
	end

	// the first request after reset always advances the beta powers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_started_q <= 1'b0;
		end else if (wr_en) begin
			step_started_q <= 1'b1;
		end
	end

endmodule
`default_nettype wire

// ===== design/adp_queue.sv =====
// Short queue of conditioned requests between front and back end.
`default_nettype none
module adp_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr_en,
	input  wire adp_pkg::work_t  wr_data,
	output logic                 full,
	input  wire logic            rd_en,
	output adp_pkg::work_t       rd_data,
	output logic                 empty
);

	adp_pkg::work_t                  slot_q [adp_pkg::QUEUE_DEPTH];
	logic [adp_pkg::Q_PTR_W-1:0]     wp_q;
	logic [adp_pkg::Q_PTR_W-1:0]     rp_q;
	logic [adp_pkg::Q_CNT_W-1:0]     cnt_q;
	logic                            do_wr;
	logic                            do_rd;

	assign full    = cnt_q == adp_pkg::Q_CNT_W'(adp_pkg::QUEUE_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_data = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == adp_pkg::Q_PTR_W'(adp_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == adp_pkg::Q_PTR_W'(adp_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/adp_div.sv =====
// Restoring divider, one quotient bit per cycle, with sticky saturation.
`default_nettype none
module adp_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [47:0] dividend,
	input  wire logic [5:0]  shamt,
	input  wire logic [49:0] divisor,
	input  wire logic [62:0] lim,
	output logic             busy,
	output logic [62:0]      quot
);

	logic        busy_q;
	logic [6:0]  cnt_q;
	logic [47:0] sr_q;
	logic [49:0] rem_q;
	logic [49:0] d_q;
	logic [63:0] q_q;
	logic [62:0] lim_q;
	logic        sat_q;
	logic [50:0] rsh;
	logic        ge;
	logic [49:0] rem_n;
	logic [63:0] q_n;

	always_comb begin
		rsh   = {rem_q, sr_q[47]};
		ge    = rsh >= 51'(d_q);
		rem_n = ge ? 50'(rsh - 51'(d_q)) : rsh[49:0];
		q_n   = {q_q[62:0], ge};
	end

	assign busy = busy_q;
	assign quot = sat_q ? lim_q : q_q[62:0];

	always_ff @(posedge clk) begin
		if (start) begin
			sr_q  <= dividend;
			rem_q <= '0;
			d_q   <= (divisor == '0) ? 50'd1 : divisor;
			q_q   <= '0;
			lim_q <= lim;
		end else if (busy_q) begin
			sr_q  <= {sr_q[46:0], 1'b0};
			rem_q <= rem_n;
			q_q   <= q_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			sat_q  <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 7'd48 + 7'(shamt);
			sat_q  <= 1'b0;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			sat_q  <= sat_q | (q_n > 64'(lim_q));
			if (cnt_q == 7'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/adp_sqrt.sv =====
// Integer square root of a 64-bit value, two radicand bits per cycle.
`default_nettype none
module adp_sqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] radicand,
	output logic             busy,
	output logic [31:0]      root
);

	logic [63:0] x_q;
	logic [63:0] res_q;
	logic [62:0] bit_q;
	logic [63:0] trial;
	logic        take;

	assign trial = res_q + 64'(bit_q);
	assign take  = x_q >= trial;
	assign busy  = bit_q != '0;
	assign root  = res_q[31:0];

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= radicand;
			res_q <= '0;
		end else if (busy) begin
			if (take) begin
				x_q   <= x_q - trial;
				res_q <= (res_q >> 1) + 64'(bit_q);
			end else begin
				res_q <= res_q >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
		end else if (start) begin
			bit_q <= 63'h4000_0000_0000_0000;
		end else if (busy) begin
			bit_q <= bit_q >> 2;
		end
	end

endmodule
`default_nettype wire

// ===== design/adp_back.sv =====
// Back end: moment stores, beta powers, bias correction and parameter step.
`default_nettype none
module adp_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire adp_pkg::cfg_t   cfg,
	input  wire logic            q_empty,
	input  wire adp_pkg::work_t  q_data,
	output logic                 deq,
	output logic                 clearing,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output adp_pkg::rsp_t        out_data
);

	adp_pkg::back_st_t st_q, st_d;

	logic [adp_pkg::MOM_W-1:0] mem_m [adp_pkg::NUM_PARAMS];
	logic [adp_pkg::MOM_W-1:0] mem_v [adp_pkg::NUM_PARAMS];

	logic [adp_pkg::ADDR_W-1:0] clr_cnt_q;
	adp_pkg::work_t             item_q;
	logic [47:0]                m_rd_q, v_rd_q;
	logic [44:0]                gsq_q;
	logic [64:0]                lo_q;
	logic [2:0]                 mi_q;
	logic [32:0]                bp1_q, bp2_q;
	logic [47:0]                mb_q, mg_q, vb_q, vg_q;
	logic [62:0]                step_q;
	logic                       m_neg_q;
	adp_pkg::rsp_t              out_q;

	logic [adp_pkg::ADDR_W-1:0] slot;
	logic [26:0]                gmag;
	logic [53:0]                gsq_full;
	logic [47:0]                m_mag;
	logic [62:0]                op_a;
	logic [32:0]                op_b;
	logic [64:0]                mul_lo;
	logic [64:0]                mul_res;
	logic signed [49:0]         t_mb, t_mg, m_new;
	logic [48:0]                v_sum;
	logic [49:0]                m_abs;
	logic [32:0]                d1, d2;
	logic [49:0]                den;
	logic signed [64:0]         p_ext, s_ext, r_full;

	logic        mem_we;
	logic        d0_start, d1_start, sq_start;
	logic [47:0] d0_a;
	logic [5:0]  d0_sh;
	logic [49:0] d0_d;
	logic [62:0] d0_lim;
	logic        d0_busy, d1_busy, sq_busy;
	logic [62:0] d0_q, d1_q;
	logic [31:0] sq_root;

	assign slot = adp_pkg::ADDR_W'(item_q.idx);

	// datapath
	always_comb begin
		gmag     = item_q.grad[27] ? 27'(-item_q.grad) : 27'(item_q.grad);
		gsq_full = 54'(gmag) * 54'(gmag) + 54'd128;
		m_mag    = m_rd_q[47] ? 48'(-m_rd_q) : m_rd_q;
		case (mi_q)
			adp_pkg::MUL_BP1: begin
				op_a = 63'(bp1_q);
				op_b = {1'b0, cfg.beta_one};
			end
			adp_pkg::MUL_BP2: begin
				op_a = 63'(bp2_q);
				op_b = {1'b0, cfg.beta_two};
			end
			adp_pkg::MUL_MB: begin
				op_a = 63'(m_mag);
				op_b = {1'b0, cfg.beta_one};
			end
			adp_pkg::MUL_MG: begin
				op_a = 63'({gmag, 16'h0000});
				op_b = adp_pkg::ONE_Q32 - {1'b0, cfg.beta_one};
			end
			adp_pkg::MUL_VB: begin
				op_a = 63'(v_rd_q);
				op_b = {1'b0, cfg.beta_two};
			end
			adp_pkg::MUL_VG: begin
				op_a = 63'(gsq_q);
				op_b = adp_pkg::ONE_Q32 - {1'b0, cfg.beta_two};
			end
			adp_pkg::MUL_STEP: begin
				op_a = d0_q;
				op_b = {1'b0, cfg.step_size};
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
		mul_lo  = 65'(op_a[31:0]) * 65'(op_b);
		mul_res = 65'(op_a[62:32]) * 65'(op_b)
			+ 65'((66'(lo_q) + 66'h8000_0000) >> 32);

		t_mb  = m_rd_q[47] ? -$signed({2'b00, mb_q}) : $signed({2'b00, mb_q});
		t_mg  = item_q.grad[27] ? -$signed({2'b00, mg_q}) : $signed({2'b00, mg_q});
		m_new = t_mb + t_mg;
		v_sum = 49'(vb_q) + 49'(vg_q);
		m_abs = m_new[49] ? 50'(-m_new) : 50'(m_new);
		d1    = (bp1_q >= adp_pkg::ONE_Q32) ? '0 : adp_pkg::ONE_Q32 - bp1_q;
		d2    = (bp2_q >= adp_pkg::ONE_Q32) ? '0 : adp_pkg::ONE_Q32 - bp2_q;
		den   = 50'({sq_root, 12'h000}) + 50'(cfg.epsilon_term);

		p_ext  = 65'(item_q.param);
		s_ext  = $signed({2'b00, step_q});
		r_full = m_neg_q ? p_ext + s_ext : p_ext - s_ext;
	end

	// divider 0 serves m_hat first, then the final ratio
	always_comb begin
		if (st_q == adp_pkg::ST_DEN) begin
			d0_a   = {1'b0, d0_q[46:0]};
			d0_sh  = adp_pkg::SH_RATIO;
			d0_d   = den;
			d0_lim = adp_pkg::LIM_RATIO;
		end else begin
			d0_a   = m_abs[47:0];
			d0_sh  = adp_pkg::SH_HAT;
			d0_d   = 50'(d1);
			d0_lim = adp_pkg::LIM_MHAT;
		end
	end

	adp_div u_div0 (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (d0_start),
		.dividend (d0_a),
		.shamt    (d0_sh),
		.divisor  (d0_d),
		.lim      (d0_lim),
		.busy     (d0_busy),
		.quot     (d0_q)
	);

	adp_div u_div1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (d1_start),
		.dividend (v_sum[47:0]),
		.shamt    (adp_pkg::SH_HAT),
		.divisor  (50'(d2)),
		.lim      (adp_pkg::LIM_VHAT),
		.busy     (d1_busy),
		.quot     (d1_q)
	);

	adp_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand ({d1_q[47:0], 16'h0000}),
		.busy     (sq_busy),
		.root     (sq_root)
	);

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			adp_pkg::ST_CLEAR: begin
				if (clr_cnt_q == adp_pkg::ADDR_W'(adp_pkg::NUM_PARAMS - 1))
					st_d = adp_pkg::ST_IDLE;
			end
			adp_pkg::ST_IDLE: begin
				if (!q_empty)
					st_d = adp_pkg::ST_RD;
			end
			adp_pkg::ST_RD:   st_d = adp_pkg::ST_MLO;
			adp_pkg::ST_MLO:  st_d = adp_pkg::ST_MHI;
			adp_pkg::ST_MHI: begin
				if (mi_q == adp_pkg::MUL_VG)
					st_d = adp_pkg::ST_MOM;
				else if (mi_q == adp_pkg::MUL_STEP)
					st_d = adp_pkg::ST_FIN;
				else
					st_d = adp_pkg::ST_MLO;
			end
			adp_pkg::ST_MOM:  st_d = adp_pkg::ST_DIVA;
			adp_pkg::ST_DIVA: begin
				if (!d0_busy && !d1_busy)
					st_d = adp_pkg::ST_SQ;
			end
			adp_pkg::ST_SQ: begin
				if (!sq_busy)
					st_d = adp_pkg::ST_DEN;
			end
			adp_pkg::ST_DEN:  st_d = adp_pkg::ST_DIVB;
			adp_pkg::ST_DIVB: begin
				if (!d0_busy)
					st_d = adp_pkg::ST_MLO;
			end
			adp_pkg::ST_FIN:  st_d = adp_pkg::ST_OUT;
			adp_pkg::ST_OUT: begin
				if (out_ready)
					st_d = adp_pkg::ST_IDLE;
			end
			default: st_d = adp_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		deq       = (st_q == adp_pkg::ST_IDLE) & ~q_empty;
		clearing  = st_q == adp_pkg::ST_CLEAR;
		mem_we    = (st_q == adp_pkg::ST_CLEAR) | (st_q == adp_pkg::ST_MOM);
		d0_start  = (st_q == adp_pkg::ST_MOM) | (st_q == adp_pkg::ST_DEN);
		d1_start  = st_q == adp_pkg::ST_MOM;
		sq_start  = (st_q == adp_pkg::ST_DIVA) & ~d0_busy & ~d1_busy;
		out_valid = st_q == adp_pkg::ST_OUT;
		out_data  = out_q;
	end

	// moment stores
	always_ff @(posedge clk) begin
		if (mem_we) begin
			if (st_q == adp_pkg::ST_CLEAR) begin
				mem_m[clr_cnt_q] <= '0;
				mem_v[clr_cnt_q] <= '0;
			end else begin
				mem_m[slot] <= 48'(m_new);
				mem_v[slot] <= v_sum[47:0];
			end
		end
		if (st_q == adp_pkg::ST_RD) begin
			m_rd_q <= mem_m[slot];
			v_rd_q <= mem_v[slot];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (deq)
			item_q <= q_data;
		if (st_q == adp_pkg::ST_RD)
			gsq_q <= 45'(gsq_full >> 8);
		if (st_q == adp_pkg::ST_MLO)
			lo_q <= mul_lo;
		if (st_q == adp_pkg::ST_MHI) begin
			case (mi_q)
				adp_pkg::MUL_MB:   mb_q   <= 48'(mul_res);
				adp_pkg::MUL_MG:   mg_q   <= 48'(mul_res);
				adp_pkg::MUL_VB:   vb_q   <= 48'(mul_res);
				adp_pkg::MUL_VG:   vg_q   <= 48'(mul_res);
				adp_pkg::MUL_STEP: step_q <= 63'(mul_res);
				default: ;
			endcase
		end
		if (st_q == adp_pkg::ST_MOM)
			m_neg_q <= m_new[49];
		if (st_q == adp_pkg::ST_FIN) begin
			out_q.out_index <= item_q.idx;
			if (r_full > 65'sd2147483647)
				out_q.new_param <= 32'sh7FFF_FFFF;
			else if (r_full < -65'sd2147483648)
				out_q.new_param <= 32'sh8000_0000;
			else
				out_q.new_param <= 32'(r_full);
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= adp_pkg::ST_CLEAR;
			clr_cnt_q <= '0;
			mi_q      <= adp_pkg::MUL_BP1;
			bp1_q     <= adp_pkg::ONE_Q32;
			bp2_q     <= adp_pkg::ONE_Q32;
		end else begin
			st_q <= st_d;
			if (st_q == adp_pkg::ST_CLEAR)
				clr_cnt_q <= clr_cnt_q + 1'b1;
			if (st_q == adp_pkg::ST_RD)
				mi_q <= item_q.adv ? adp_pkg::MUL_BP1 : adp_pkg::MUL_MB;
			if (st_q == adp_pkg::ST_MHI && mi_q != adp_pkg::MUL_VG)
				mi_q <= mi_q + 1'b1;
			if (st_q == adp_pkg::ST_DIVB && !d0_busy)
				mi_q <= adp_pkg::MUL_STEP;
			if (st_q == adp_pkg::ST_MHI && mi_q == adp_pkg::MUL_BP1)
				bp1_q <= mul_res[32:0];
			if (st_q == adp_pkg::ST_MHI && mi_q == adp_pkg::MUL_BP2)
				bp2_q <= mul_res[32:0];
		end
	end

	a_no_deq_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == adp_pkg::ST_CLEAR) |-> !deq)
		else $error("request taken during moment clear");

	a_we_states: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (st_q == adp_pkg::ST_CLEAR || st_q == adp_pkg::ST_MOM))
		else $error("moment store written outside clear or update");

	a_sqrt_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		sq_start |=> sq_busy && !d1_busy)
		else $error("root started while divider busy");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(st_q) == adp_pkg::ST_FIN)
		else $error("result shown without final step");

endmodule
`default_nettype wire

// ===== design/adam_param_update.sv =====
// Top level of the Adam parameter update block.
// Adam update for one parameter per request: gradient plus L2 decay, clipped to
// +-5.0 (zero when flagged invalid), first/second moment update per index (Q8.40),
// bias correction from running beta powers, result saturated to Q8.24. After reset
// the block clears all 1024 entries of both moment stores, one entry per cycle;
// full stays high meanwhile, configuration writes are still taken. Each request then
// passes the bit-serial dividers of the back end (80 steps for the two bias
// corrections run in parallel, 72 for the final ratio) and the 32-step square root
// that lies between them; two more products come first when the beta powers advance.
// A two-entry queue holds requests while the back end works, and a one-entry result
// register lets the next request start while a result waits for pop. Configuration
// writes are always ready and must only be made while idle.
`default_nettype none
module adam_param_update (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	output logic                full,
	input  wire adp_pkg::req_t  request,
	output logic                empty,
	input  wire logic           pop,
	output adp_pkg::rsp_t       result,
	input  wire logic           valid,
	output logic                ready,
	input  wire logic [2:0]     cfg_index,
	input  wire logic [47:0]    cfg_data
);

	adp_pkg::cfg_t  cfg_q;
	adp_pkg::work_t wr_data, rd_data;
	logic           wr_en, q_full, q_empty, deq, clearing;
	logic           b_valid, b_ready;
	adp_pkg::rsp_t  b_data;
	adp_pkg::rsp_t  res_q;
	logic           res_v_q;

	// configuration registers
	assign ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_size    <= adp_pkg::RST_LR;
			cfg_q.l2_decay     <= adp_pkg::RST_L2;
			cfg_q.beta_one     <= adp_pkg::RST_B1;
			cfg_q.beta_two     <= adp_pkg::RST_B2;
			cfg_q.epsilon_term <= adp_pkg::RST_EPS;
		end else if (valid) begin
			case (cfg_index)
				adp_pkg::CFG_LR:  cfg_q.step_size    <= cfg_data[31:0];
				adp_pkg::CFG_L2:  cfg_q.l2_decay     <= cfg_data[31:0];
				adp_pkg::CFG_B1:  cfg_q.beta_one     <= cfg_data[31:0];
				adp_pkg::CFG_B2:  cfg_q.beta_two     <= cfg_data[31:0];
				adp_pkg::CFG_EPS: cfg_q.epsilon_term <= cfg_data;
				default: ;
			endcase
		end
	end

	adp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.request  (request),
		.l2_decay (cfg_q.l2_decay),
		.q_full   (q_full),
		.clearing (clearing),
		.full     (full),
		.wr_en    (wr_en),
		.wr_data  (wr_data)
	);

	adp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.full    (q_full),
		.rd_en   (deq),
		.rd_data (rd_data),
		.empty   (q_empty)
	);

	adp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_data    (rd_data),
		.deq       (deq),
		.clearing  (clearing),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.out_data  (b_data)
	);

	// result register: back end may move on while a result waits
	assign b_ready = ~res_v_q | pop;
	assign empty   = ~res_v_q;
	assign result  = res_q;

	always_ff @(posedge clk) begin
		if (b_valid && b_ready)
			res_q <= b_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (b_valid && b_ready) begin
			res_v_q <= 1'b1;
		end else if (pop) begin
			res_v_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire
